/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the scanner checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define TDCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every clock edge, reset included
`define TDCS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* hdl/tdcs_pkg.sv */
// ----------------------------------------------------------------------------
// tdcs_pkg
// widths, codes and shared types of the table-driven character scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdcs_pkg;

    // default sizes
    localparam int TDCS_NUM_TABLES = 16;
    localparam int TDCS_NUM_SLOTS  = 16;
    localparam int TDCS_CHAR_SET   = 256;

    // word field widths
    localparam int FUNC_W  = 3;
    localparam int TID_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int SIDX_W  = 4;
    localparam int PUT_W   = 8;
    localparam int KIND_W  = 3;
    localparam int NXT_W   = 4;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 16;
    localparam int TOK_W   = 8;

    // width used to range-check indices against sizes up to 256
    localparam int EXT_W   = 9;

    // function codes
    localparam logic [FUNC_W-1:0] FN_START = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SCAN  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_EOS   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_WRITE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PLUG  = 3'd5;

    // action kinds
    localparam logic [KIND_W-1:0] K_CONTIN = 3'd0;
    localparam logic [KIND_W-1:0] K_STOP   = 3'd1;
    localparam logic [KIND_W-1:0] K_STOPSH = 3'd2;
    localparam logic [KIND_W-1:0] K_ERROR  = 3'd3;
    localparam logic [KIND_W-1:0] K_GOTO   = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_STOP     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FAULT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_EOS      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // one action slot as stored
    typedef struct packed {
        logic [PUT_W-1:0]  put;
        logic [KIND_W-1:0] kind;
        logic [NXT_W-1:0]  nxt_tbl;
    } slot_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_start;
        logic map_rd;
        logic slot_wr;
        logic slot_rd_scan;
        logic scan_commit;
        logic emit_eos;
        logic find_clr;
        logic find_rd;
        logic find_next;
        logic plug_wr;
        logic fill_clr;
        logic fill_wr;
        logic emit_nf;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_start_ok;
        logic in_scan_ok;
        logic in_eos_ok;
        logic in_wr_ok;
        logic in_find_ok;
        logic eval_needs_out;
        logic out_free;
        logic find_hit;
        logic find_last;
        logic is_clear;
        logic fill_last;
    } dp_status_t;

endpackage

/* hdl/tdcs_item_if.sv */
// ----------------------------------------------------------------------------
// tdcs_item_if
// valid/ready channel carrying one command word into the scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tdcs_item_if
    import tdcs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TID_W-1:0]  table_id;
    logic [CHAR_W-1:0] char_code;
    logic [SIDX_W-1:0] slot_index;
    logic [PUT_W-1:0]  put_code;
    logic [KIND_W-1:0] act_kind;
    logic [NXT_W-1:0]  next_table;

    modport source (
        output valid, func, table_id, char_code, slot_index, put_code, act_kind,
               next_table,
        input  ready
    );

    modport sink (
        input  valid, func, table_id, char_code, slot_index, put_code, act_kind,
               next_table,
        output ready
    );
endinterface

/* hdl/tdcs_result_if.sv */
// ----------------------------------------------------------------------------
// tdcs_result_if
// valid/ready channel carrying one scan result word out of the scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tdcs_result_if
    import tdcs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  match_length;
    logic [TOK_W-1:0]  token_type;

    modport source (
        output valid, status, match_length, token_type,
        input  ready
    );

    modport sink (
        input  valid, status, match_length, token_type,
        output ready
    );
endinterface

/* hdl/tdcs_ctrl.sv */
// ----------------------------------------------------------------------------
// tdcs_ctrl
// sequencer: scan steps, slot search, map fill and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdcs_ctrl
    import tdcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SLOT     = 8'b0000_0010,
        S_EVAL     = 8'b0000_0100,
        S_EOS      = 8'b0000_1000,
        S_FIND_RD  = 8'b0001_0000,
        S_FIND_CHK = 8'b0010_0000,
        S_FILL     = 8'b0100_0000,
        S_NFOUND   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (st.in_start_ok)
                    begin
                        cmd.do_start = 1'b1;
                    end
                    else if (st.in_scan_ok)
                    begin
                        cmd.map_rd = 1'b1;
                        state_next = S_SLOT;
                    end
                    else if (st.in_eos_ok)
                    begin
                        state_next = S_EOS;
                    end
                    else if (st.in_wr_ok)
                    begin
                        cmd.slot_wr = 1'b1;
                    end
                    else if (st.in_find_ok)
                    begin
                        cmd.find_clr = 1'b1;
                        state_next   = S_FIND_RD;
                    end
                end
            end
            S_SLOT:
            begin
                cmd.slot_rd_scan = 1'b1;
                state_next       = S_EVAL;
            end
            S_EVAL:
            begin
                if (!st.eval_needs_out || st.out_free)
                begin
                    cmd.scan_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_EOS:
            begin
                if (st.out_free)
                begin
                    cmd.emit_eos = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FIND_RD:
            begin
                cmd.find_rd = 1'b1;
                state_next  = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                if (st.find_hit)
                begin
                    if (st.is_clear)
                    begin
                        cmd.fill_clr = 1'b1;
                        state_next   = S_FILL;
                    end
                    else
                    begin
                        cmd.plug_wr = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (st.find_last)
                begin
                    state_next = S_NFOUND;
                end
                else
                begin
                    cmd.find_next = 1'b1;
                    state_next    = S_FIND_RD;
                end
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (st.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_NFOUND:
            begin
                if (st.out_free)
                begin
                    cmd.emit_nf = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/tdcs_dp.sv */
// ----------------------------------------------------------------------------
// tdcs_dp
// class map and slot memories, scan registers and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdcs_dp
    import tdcs_pkg::*;
#(
    parameter int NUM_TABLES = TDCS_NUM_TABLES,
    parameter int NUM_SLOTS  = TDCS_NUM_SLOTS,
    parameter int CHAR_SET   = TDCS_CHAR_SET
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [FUNC_W-1:0] func,
    input  logic [TID_W-1:0]  table_id,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [SIDX_W-1:0] slot_index,
    input  logic [PUT_W-1:0]  put_code,
    input  logic [KIND_W-1:0] act_kind,
    input  logic [NXT_W-1:0]  next_table,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        st,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [STAT_W-1:0] status,
    output logic [LEN_W-1:0]  match_length,
    output logic [TOK_W-1:0]  token_type
);

    localparam int TBL_W     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CHR_W     = $clog2(CHAR_SET);
    localparam int MAP_AW    = TBL_W + CHR_W;
    localparam int SLOT_AW   = TBL_W + SLOT_W;
    localparam int MAP_DEPTH  = 2 ** MAP_AW;
    localparam int SLOT_DEPTH = 2 ** SLOT_AW;

    localparam logic [EXT_W-1:0]  TBL_LIM   = EXT_W'(NUM_TABLES);
    localparam logic [EXT_W-1:0]  SLOT_LIM  = EXT_W'(NUM_SLOTS);
    localparam logic [EXT_W-1:0]  CHR_LIM   = EXT_W'(CHAR_SET);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [CHR_W-1:0]  CHR_LAST  = CHR_W'(CHAR_SET - 1);
    localparam logic [LEN_W-1:0]  LEN_MAX   = '1;

    // memories
    logic [SLOT_W-1:0] map_mem  [0:MAP_DEPTH-1];
    slot_entry_t       slot_mem [0:SLOT_DEPTH-1];

    logic [SLOT_W-1:0] map_rd_reg;
    slot_entry_t       slot_rd_reg;

    // latched word
    logic [TBL_W-1:0]  tid_reg;
    logic [CHR_W-1:0]  ch_reg;
    logic              ch_ok_reg;
    logic [KIND_W-1:0] kind_reg;
    logic              clear_reg;

    // scan state
    logic [TBL_W-1:0]  cur_table_reg, cur_table_next;
    logic [TOK_W-1:0]  token_reg,     token_next;
    logic [LEN_W-1:0]  count_reg,     count_next;
    logic              done_reg,      done_next;

    // search and fill counters
    logic [SLOT_W-1:0] idx_reg;
    logic [CHR_W-1:0]  fill_reg;

    // result register
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [LEN_W-1:0]  out_len_reg,    out_len_next;
    logic [TOK_W-1:0]  out_tok_reg,    out_tok_next;
    logic              out_load;

    // live word decode
    logic [EXT_W-1:0]  tid_ext, sidx_ext, nxt_ext, ch_ext;
    logic              tid_ok, sidx_ok, nxt_ok, ch_ok;
    logic [TBL_W-1:0]  tid_idx;
    logic [SLOT_W-1:0] sidx_idx;
    logic [CHR_W-1:0]  chr_idx;

    assign tid_ext  = EXT_W'(table_id);
    assign sidx_ext = EXT_W'(slot_index);
    assign nxt_ext  = EXT_W'(next_table);
    assign ch_ext   = EXT_W'(char_code);
    assign tid_ok   = (tid_ext < TBL_LIM);
    assign sidx_ok  = (sidx_ext < SLOT_LIM);
    assign nxt_ok   = (nxt_ext < TBL_LIM);
    assign ch_ok    = (ch_ext < CHR_LIM);
    assign tid_idx  = tid_ext[TBL_W-1:0];
    assign sidx_idx = sidx_ext[SLOT_W-1:0];
    assign chr_idx  = ch_ext[CHR_W-1:0];

    // slot selection for a scan step
    logic [EXT_W-1:0]  map_ext;
    logic [SLOT_W-1:0] slot_sel;

    assign map_ext  = EXT_W'(map_rd_reg);
    assign slot_sel = (!ch_ok_reg || (map_ext >= SLOT_LIM)) ? '0 : map_rd_reg;

    // evaluation of the selected slot
    logic [EXT_W-1:0] snxt_ext;
    logic             snxt_ok;
    logic [TOK_W-1:0] tok_sel;
    logic [LEN_W-1:0] count_inc;

    assign snxt_ext  = EXT_W'(slot_rd_reg.nxt_tbl);
    assign snxt_ok   = (snxt_ext < TBL_LIM);
    assign tok_sel   = (slot_rd_reg.put != '0) ? slot_rd_reg.put : token_reg;
    assign count_inc = (count_reg == LEN_MAX) ? count_reg : count_reg + LEN_W'(1);

    always_comb
    begin
        st                = '0;
        st.in_start_ok    = (func == FN_START) && tid_ok;
        st.in_scan_ok     = (func == FN_SCAN) && !done_reg;
        st.in_eos_ok      = (func == FN_EOS) && !done_reg;
        st.in_wr_ok       = (func == FN_WRITE) && tid_ok && sidx_ok && nxt_ok;
        st.in_find_ok     = (func inside {FN_CLEAR, FN_PLUG}) && tid_ok;
        st.eval_needs_out = slot_rd_reg.kind inside {K_STOP, K_STOPSH, K_ERROR};
        st.out_free       = !out_valid_reg || out_ready;
        st.find_hit       = (slot_rd_reg.kind == kind_reg);
        st.find_last      = (idx_reg == SLOT_LAST);
        st.is_clear       = clear_reg;
        st.fill_last      = (fill_reg == CHR_LAST);
    end

    // memory ports
    logic              map_we;
    logic [MAP_AW-1:0] map_waddr;
    logic               slot_re;
    logic [SLOT_AW-1:0] slot_raddr;

    assign map_we     = cmd.fill_wr || (cmd.plug_wr && ch_ok_reg);
    assign map_waddr  = cmd.fill_wr ? {tid_reg, fill_reg} : {tid_reg, ch_reg};
    assign slot_re    = cmd.find_rd || cmd.slot_rd_scan;
    assign slot_raddr = cmd.find_rd ? {tid_reg, idx_reg} : {cur_table_reg, slot_sel};

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= idx_reg;
        end
        if (cmd.map_rd)
        begin
            map_rd_reg <= map_mem[{cur_table_reg, chr_idx}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.slot_wr)
        begin
            slot_mem[{tid_idx, sidx_idx}] <= '{put: put_code, kind: act_kind,
                                               nxt_tbl: next_table};
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[slot_raddr];
        end
    end

    // scan state and result next values
    always_comb
    begin
        cur_table_next  = cur_table_reg;
        token_next      = token_reg;
        count_next      = count_reg;
        done_next       = done_reg;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        out_tok_next    = out_tok_reg;

        if (cmd.do_start)
        begin
            cur_table_next = tid_idx;
            token_next     = '0;
            count_next     = '0;
            done_next      = 1'b0;
        end

        if (cmd.scan_commit)
        begin
            case (slot_rd_reg.kind)
                K_STOP:
                begin
                    token_next      = tok_sel;
                    count_next      = count_inc;
                    done_next       = 1'b1;
                    out_load        = 1'b1;
                    out_status_next = ST_STOP;
                    out_len_next    = count_inc;
                    out_tok_next    = tok_sel;
                end
                K_STOPSH:
                begin
                    token_next      = tok_sel;
                    done_next       = 1'b1;
                    out_load        = 1'b1;
                    out_status_next = ST_STOP;
                    out_len_next    = count_reg;
                    out_tok_next    = tok_sel;
                end
                K_ERROR:
                begin
                    token_next      = '0;
                    done_next       = 1'b1;
                    out_load        = 1'b1;
                    out_status_next = ST_FAULT;
                    out_len_next    = '0;
                    out_tok_next    = '0;
                end
                K_GOTO:
                begin
                    token_next = tok_sel;
                    count_next = count_inc;
                    if (snxt_ok)
                    begin
                        cur_table_next = snxt_ext[TBL_W-1:0];
                    end
                end
                default:
                begin
                    // contin, and unknown kinds behave the same
                    token_next = tok_sel;
                    count_next = count_inc;
                end
            endcase
        end

        if (cmd.emit_eos)
        begin
            done_next       = 1'b1;
            out_load        = 1'b1;
            out_status_next = ST_EOS;
            out_len_next    = count_reg;
            out_tok_next    = token_reg;
        end

        if (cmd.emit_nf)
        begin
            out_load        = 1'b1;
            out_status_next = ST_NOTFOUND;
            out_len_next    = '0;
            out_tok_next    = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_table_reg <= '0;
            token_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            cur_table_reg <= cur_table_next;
            token_reg     <= token_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.find_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.find_next)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (cmd.fill_clr)
            begin
                fill_reg <= '0;
            end
            else if (cmd.fill_wr)
            begin
                fill_reg <= fill_reg + CHR_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            tid_reg   <= tid_idx;
            ch_reg    <= chr_idx;
            ch_ok_reg <= ch_ok;
            kind_reg  <= act_kind;
            clear_reg <= (func == FN_CLEAR);
        end
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_len_reg    <= out_len_next;
            out_tok_reg    <= out_tok_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign match_length = out_len_reg;
    assign token_type   = out_tok_reg;

endmodule

/* hdl/table_driven_char_scanner_unit.sv */
// input busy per word: start, write slot and dropped words are taken in S_IDLE alone;
//   end of subject waits in S_EOS, scan byte is map read, slot read, evaluate
// clear map / plug byte: a read and a check per slot searched, plug writes in the last;
//   a clear then fills CHAR_SET entries, 1 per cycle; kind not found passes S_NFOUND
// throughput is one word at a time; a word with a result also waits for a free output reg
// reset: async active low, clears scan state and result valid flag; memories keep garbage
// ----------------------------------------------------------------------------
// table_driven_char_scanner_unit
// table-driven character scanner: per-table class maps send each subject
// byte to an action slot that sets the token type and steers the scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module table_driven_char_scanner_unit
    import tdcs_pkg::*;
#(
    parameter int NUM_TABLES = TDCS_NUM_TABLES,
    parameter int NUM_SLOTS  = TDCS_NUM_SLOTS,
    parameter int CHAR_SET   = TDCS_CHAR_SET
)
(
    input  logic          clk,
    input  logic          rst_n,
    tdcs_item_if.sink     item,
    tdcs_result_if.source result
);

    // controller and datapath talk only through these two structs
    ctrl_cmd_t  cmd;
    dp_status_t st;

    // the sequencer owns the input handshake; a word is only taken when the
    // previous one has finished its memory work, results are decoupled by
    // the output register inside the datapath
    tdcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: the class map (table x byte -> slot) and the slot memory
    // (table x slot -> token, kind, next table) are single-port-read memories
    // with registered read data, so a scan byte is two chained reads
    tdcs_dp #(
        .NUM_TABLES (NUM_TABLES),
        .NUM_SLOTS  (NUM_SLOTS),
        .CHAR_SET   (CHAR_SET)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (item.func),
        .table_id     (item.table_id),
        .char_code    (item.char_code),
        .slot_index   (item.slot_index),
        .put_code     (item.put_code),
        .act_kind     (item.act_kind),
        .next_table   (item.next_table),
        .cmd          (cmd),
        .st           (st),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .status       (result.status),
        .match_length (result.match_length),
        .token_type   (result.token_type)
    );

endmodule

/* hdl/tdcs_checker.sv */
// ----------------------------------------------------------------------------
// tdcs_checker
// port-level checks on the scanner result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdcs_checker
    import tdcs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic [FUNC_W-1:0] item_func,
    input logic              res_valid,
    input logic              res_ready,
    input logic [STAT_W-1:0] res_status,
    input logic [LEN_W-1:0]  res_len,
    input logic [TOK_W-1:0]  res_tok
);

    // a stalled result stays
    `TDCS_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")

    // a stalled result does not change
    `TDCS_ASSERT(a_res_stable, res_valid && !res_ready |=> $stable(res_status) && $stable(res_len) && $stable(res_tok), "stalled result changed")

    // error and not-found carry no length and no token
    `TDCS_ASSERT(a_res_zero, res_valid && (res_status == ST_FAULT || res_status == ST_NOTFOUND) |-> (res_len == '0) && (res_tok == '0), "error result carries data")

    // start and slot writes never produce a result
    `TDCS_ASSERT(a_quiet_words, item_valid && item_ready && (item_func == FN_START || item_func == FN_WRITE) |=> !$rose(res_valid), "result after a silent word")

    // no result while reset is held
    `TDCS_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !res_valid, "result valid in reset")

endmodule

bind table_driven_char_scanner_unit tdcs_checker u_tdcs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .item_func  (item.func),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_status (result.status),
    .res_len    (result.match_length),
    .res_tok    (result.token_type)
);
